[rtl/core/fslp_pkg.sv]
// ----------------------------------------------------------------------------
// fslp_pkg - shared types and constants of the flash sector item log
// Sector geometry, command, operation, status and phase codes, the pointer
// state record and the result burst record, plus small helper functions.
// ----------------------------------------------------------------------------
package fslp_pkg;

	// Sector geometry and field widths
	localparam int SECTOR_BYTES   = 4096;
	localparam int MAX_ITEM_BYTES = 256;
	localparam int ADDR_BITS      = 24;
	localparam int OFF_BITS       = $clog2(SECTOR_BYTES);
	localparam int SIZE_BITS      = 9;
	localparam int SLOT_BITS      = 13;
	localparam int COUNT_BITS     = 13;
	localparam int INDEX_BITS     = 12;
	localparam int CMD_BITS       = 3;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 24;
	localparam int MAX_RESULTS    = 3;
	localparam int CALC_BITS      = ((OFF_BITS > SIZE_BITS) ? OFF_BITS : SIZE_BITS) + 2;

	// Reset values of the configuration registers
	localparam logic [ADDR_BITS-1:0] BASE_RESET  = '0;
	localparam logic [SIZE_BITS-1:0] SIZE_RESET  = SIZE_BITS'(16);
	localparam logic [SLOT_BITS-1:0] SLOTS_RESET = SLOT_BITS'(256);

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_BASE      = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ITEM_SIZE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SLOTS     = 2'd2;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_SCAN   = 3'd0,
		CMD_CHECK  = 3'd1,
		CMD_APPEND = 3'd2,
		CMD_VERIFY = 3'd3,
		CMD_READ   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_ERASE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_WAIT      = 2'd1,
		ST_FAIL      = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_SCAN_LAST = 2'd1,
		PH_SCAN_FWD  = 2'd2,
		PH_VERIFY    = 2'd3
	} phase_t;

	// Pointer state of the log
	typedef struct packed {
		logic [OFF_BITS-1:0]   wr_off;
		logic [OFF_BITS-1:0]   rd_off;
		logic [OFF_BITS-1:0]   scan_off;
		logic [OFF_BITS-1:0]   start_off;
		logic [COUNT_BITS-1:0] count;
		phase_t                phase;
	} state_t;

	// Up to three flash requests answering one command
	typedef struct packed {
		logic [1:0]                             n;
		logic [MAX_RESULTS-1:0][1:0]            op;
		logic [MAX_RESULTS-1:0][ADDR_BITS-1:0]  addr;
		logic [1:0]                             status;
		logic [COUNT_BITS-1:0]                  count;
		logic                                   full;
		logic                                   empty;
	} burst_t;

	// Clamp the item size into 1 .. MAX_ITEM_BYTES
	function automatic logic [SIZE_BITS-1:0] item_bytes(input logic [SIZE_BITS-1:0] size);
		logic [SIZE_BITS-1:0] s;
		s = size;
		if (s == '0)
			s = SIZE_BITS'(1);
		if (int'(s) > MAX_ITEM_BYTES)
			s = SIZE_BITS'(MAX_ITEM_BYTES);
		return s;
	endfunction

	// Byte offset within the sector to flash byte address
	function automatic logic [ADDR_BITS-1:0] flash_address(input logic [ADDR_BITS-1:0] base,
			input logic [OFF_BITS-1:0] off);
		return base + ADDR_BITS'(off);
	endfunction

	// Saturating item count increment
	function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] c);
		return (c == '1) ? c : c + COUNT_BITS'(1);
	endfunction

endpackage

[rtl/core/flash_sector_item_log_pointers_core.sv]
// ----------------------------------------------------------------------------
// flash_sector_item_log_pointers_core - pointer keeper of a flash item log
// Holds write offset, read offset and item count of a log of fixed-size
// items in one flash sector and answers each command with flash requests.
//
// Usage:
//   Command channel: cmd, check_flag and item_index are taken at a rising
//   edge with start high and busy low. Commands are scan, slot check result,
//   append, verify result and indexed read.
//   Result channel: each request (flash_op, flash_addr, status, item_count,
//   is_full, is_empty, last) is shown for one cycle with done high; last
//   marks the final request of a command. The receiver cannot stall.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 base address, 1 item size, 2 slots in sector) at once.
//   Timing: a taken command is registered, then its burst is registered
//   and its first request shown; further requests follow in consecutive
//   cycles. Throughput: one command a cycle when each gives one request;
//   an append or a retried verify gives two or three and holds busy until
//   its last request is shown, as there is a single result port.
//   Reset: pointers and count clear, phase goes idle, no request is shown.
// ----------------------------------------------------------------------------
module flash_sector_item_log_pointers_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [fslp_pkg::CMD_BITS-1:0]      cmd,
	input  logic                               check_flag,
	input  logic [fslp_pkg::INDEX_BITS-1:0]    item_index,
	input  logic                               cfg_we,
	input  logic [fslp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [fslp_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output logic                               done,
	output logic [1:0]                         flash_op,
	output logic [fslp_pkg::ADDR_BITS-1:0]     flash_addr,
	output logic [1:0]                         status,
	output logic [fslp_pkg::COUNT_BITS-1:0]    item_count,
	output logic                               is_full,
	output logic                               is_empty,
	output logic                               last
);

	localparam int NR = fslp_pkg::MAX_RESULTS;

	logic [fslp_pkg::ADDR_BITS-1:0]  base_q;
	logic [fslp_pkg::SIZE_BITS-1:0]  size_q;
	logic [fslp_pkg::SLOT_BITS-1:0]  slots_q;

	logic                            vld_s1;
	logic [fslp_pkg::CMD_BITS-1:0]   cmd_s1;
	logic                            flag_s1;
	logic [fslp_pkg::INDEX_BITS-1:0] idx_s1;

	fslp_pkg::state_t state_q;
	fslp_pkg::state_t state_nxt;
	fslp_pkg::burst_t burst;

	logic [NR-1:0][1:0]                     op_q;
	logic [NR-1:0][fslp_pkg::ADDR_BITS-1:0] addr_q;
	logic [1:0]                             status_q;
	logic [fslp_pkg::COUNT_BITS-1:0]        count_q;
	logic                                   full_q;
	logic                                   empty_q;
	logic [1:0]                             rem_q;

	logic accept;

	// Hold off a request while a burst still has more than its last one left
	assign busy   = (rem_q > 2'd1) || (vld_s1 && burst.n > 2'd1);
	assign accept = start && !busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= fslp_pkg::BASE_RESET;
			size_q  <= fslp_pkg::SIZE_RESET;
			slots_q <= fslp_pkg::SLOTS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fslp_pkg::CFG_BASE:      base_q  <= cfg_data[fslp_pkg::ADDR_BITS-1:0];
				fslp_pkg::CFG_ITEM_SIZE: size_q  <= cfg_data[fslp_pkg::SIZE_BITS-1:0];
				fslp_pkg::CFG_SLOTS:     slots_q <= cfg_data[fslp_pkg::SLOT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register the command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd;
			flag_s1 <= check_flag;
			idx_s1  <= item_index;
		end
	end

	fslp_step u_step (
		.cmd             (cmd_s1),
		.check_flag      (flag_s1),
		.item_index      (idx_s1),
		.base_address    (base_q),
		.item_size       (size_q),
		.slots_in_sector (slots_q),
		.cur             (state_q),
		.nxt             (state_nxt),
		.burst           (burst)
	);

	// Pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.wr_off    <= '0;
			state_q.rd_off    <= '0;
			state_q.scan_off  <= '0;
			state_q.start_off <= '0;
			state_q.count     <= '0;
			state_q.phase     <= fslp_pkg::PH_IDLE;
		end else if (vld_s1) begin
			state_q <= state_nxt;
		end
	end

	// Request burst count: load a new burst, else drop the one just shown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (vld_s1) begin
			rem_q <= burst.n;
		end else if (rem_q != '0) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	// Request payload: load, or advance the queue by one
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			op_q     <= burst.op;
			addr_q   <= burst.addr;
			status_q <= burst.status;
			count_q  <= burst.count;
			full_q   <= burst.full;
			empty_q  <= burst.empty;
		end else if (rem_q != '0) begin
			for (int i = 0; i < NR - 1; i++) begin
				op_q[i]   <= op_q[i+1];
				addr_q[i] <= addr_q[i+1];
			end
		end
	end

	// Present the head of the burst
	assign done       = (rem_q != '0);
	assign last       = (rem_q == 2'd1);
	assign flash_op   = op_q[0];
	assign flash_addr = addr_q[0];
	assign status     = status_q;
	assign item_count = count_q;
	assign is_full    = full_q;
	assign is_empty   = empty_q;

`ifndef SYNTHESIS
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done)
		else $error("burst broken off before its last request");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> rem_q <= 2'd1)
		else $error("new burst loaded over pending requests");

	a_erase_then_write: assert property (@(posedge clk) disable iff (!arst_n)
		done && flash_op == fslp_pkg::OP_ERASE |=> done && flash_op == fslp_pkg::OP_WRITE)
		else $error("erase not followed by write");

	a_write_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && flash_op == fslp_pkg::OP_WRITE |-> !last)
		else $error("write request without read-back");
`endif

endmodule

[rtl/core/fslp_step.sv]
// ----------------------------------------------------------------------------
// fslp_step - command decoder and pointer update
// Works out, for one registered command, the next pointer state and the
// burst of up to three flash requests that answers it.
// ----------------------------------------------------------------------------
module fslp_step (
	input  logic [fslp_pkg::CMD_BITS-1:0]   cmd,
	input  logic                            check_flag,
	input  logic [fslp_pkg::INDEX_BITS-1:0] item_index,
	input  logic [fslp_pkg::ADDR_BITS-1:0]  base_address,
	input  logic [fslp_pkg::SIZE_BITS-1:0]  item_size,
	input  logic [fslp_pkg::SLOT_BITS-1:0]  slots_in_sector,
	input  fslp_pkg::state_t                cur,
	output fslp_pkg::state_t                nxt,
	output fslp_pkg::burst_t                burst
);

	localparam int OB = fslp_pkg::OFF_BITS;
	localparam int CB = fslp_pkg::CALC_BITS;
	localparam int LPB = fslp_pkg::SLOT_BITS + fslp_pkg::SIZE_BITS;
	localparam int IPB = fslp_pkg::INDEX_BITS + fslp_pkg::SIZE_BITS;
	localparam logic [CB-1:0] SECTOR   = CB'(fslp_pkg::SECTOR_BYTES);
	localparam logic [CB-1:0] OFF_MASK = CB'(fslp_pkg::SECTOR_BYTES - 1);

	logic [fslp_pkg::SIZE_BITS-1:0] it;
	logic [CB-1:0] it_w;
	logic [CB-1:0] two_it;
	logic [fslp_pkg::SLOT_BITS-1:0] slots_m1;
	logic [LPB-1:0] last_prod;
	logic [IPB-1:0] idx_prod;
	logic [OB-1:0] last_off;
	logic [OB-1:0] idx_off;
	logic [CB-1:0] scan_next;
	logic [CB-1:0] att_next;
	logic          att_erase;
	logic [OB-1:0] att_wr;
	logic          do_att;

	// Slot may be read by the forward scan
	function automatic logic may_read(input logic [CB-1:0] off, input logic [CB-1:0] twice);
		return (twice <= SECTOR) && (off <= SECTOR - twice);
	endfunction

	// Size, scan start and indexed read offsets
	always_comb begin
		it        = fslp_pkg::item_bytes(item_size);
		it_w      = CB'(it);
		two_it    = CB'({it, 1'b0});
		slots_m1  = slots_in_sector - fslp_pkg::SLOT_BITS'(1);
		last_prod = LPB'(slots_m1) * LPB'(it);
		idx_prod  = IPB'(item_index) * IPB'(it);
		last_off  = last_prod[OB-1:0];
		idx_off   = idx_prod[OB-1:0];
		scan_next = CB'(cur.scan_off) + it_w;
	end

	// Append attempt: erase on offset zero, then write and read back
	always_comb begin
		att_erase = (cur.wr_off == '0);
		att_next  = CB'(cur.wr_off) + it_w;
		att_wr    = (att_next + it_w > SECTOR) ? '0 : att_next[OB-1:0];
	end

	// Decode the command
	always_comb begin
		nxt          = cur;
		burst        = '0;
		burst.op     = {fslp_pkg::MAX_RESULTS{fslp_pkg::OP_NONE}};
		burst.status = fslp_pkg::ST_OK;
		do_att       = 1'b0;

		unique case (cmd)
			fslp_pkg::CMD_SCAN: begin
				nxt.scan_off  = last_off;
				nxt.phase     = fslp_pkg::PH_SCAN_LAST;
				burst.n       = 2'd1;
				burst.op[0]   = fslp_pkg::OP_READ;
				burst.addr[0] = fslp_pkg::flash_address(base_address, last_off);
				burst.status  = fslp_pkg::ST_WAIT;
			end
			fslp_pkg::CMD_CHECK: begin
				if (cur.phase == fslp_pkg::PH_SCAN_LAST) begin
					burst.n = 2'd1;
					nxt.wr_off = '0;
					if (check_flag) begin
						// last slot dirty: sector is full
						nxt.rd_off = cur.scan_off;
						nxt.count  = fslp_pkg::COUNT_BITS'(slots_in_sector);
						nxt.phase  = fslp_pkg::PH_IDLE;
					end else begin
						nxt.rd_off   = '0;
						nxt.count    = '0;
						nxt.scan_off = '0;
						if (may_read('0, two_it)) begin
							nxt.phase     = fslp_pkg::PH_SCAN_FWD;
							burst.op[0]   = fslp_pkg::OP_READ;
							burst.addr[0] = fslp_pkg::flash_address(base_address, '0);
							burst.status  = fslp_pkg::ST_WAIT;
						end else begin
							nxt.phase = fslp_pkg::PH_IDLE;
						end
					end
				end else if (cur.phase == fslp_pkg::PH_SCAN_FWD) begin
					burst.n = 2'd1;
					if (check_flag) begin
						// dirty slot: count it and step on
						nxt.count  = fslp_pkg::count_inc(cur.count);
						nxt.rd_off = cur.scan_off;
						if (scan_next <= OFF_MASK && may_read(scan_next, two_it)) begin
							nxt.scan_off  = scan_next[OB-1:0];
							burst.op[0]   = fslp_pkg::OP_READ;
							burst.addr[0] = fslp_pkg::flash_address(base_address,
								scan_next[OB-1:0]);
							burst.status  = fslp_pkg::ST_WAIT;
						end else begin
							nxt.phase = fslp_pkg::PH_IDLE;
						end
					end else begin
						// first clean slot takes the next write
						nxt.wr_off = cur.scan_off;
						nxt.phase  = fslp_pkg::PH_IDLE;
					end
				end
			end
			fslp_pkg::CMD_APPEND: begin
				nxt.start_off = cur.wr_off;
				do_att        = 1'b1;
			end
			fslp_pkg::CMD_VERIFY: begin
				if (cur.phase == fslp_pkg::PH_VERIFY) begin
					if (check_flag) begin
						nxt.phase = fslp_pkg::PH_IDLE;
						burst.n   = 2'd1;
					end else if (cur.start_off == cur.wr_off) begin
						// gone all the way round
						nxt.phase    = fslp_pkg::PH_IDLE;
						burst.n      = 2'd1;
						burst.status = fslp_pkg::ST_FAIL;
					end else begin
						do_att = 1'b1;
					end
				end
			end
			fslp_pkg::CMD_READ: begin
				burst.n = 2'd1;
				if (fslp_pkg::COUNT_BITS'(item_index) >= cur.count) begin
					burst.status = fslp_pkg::ST_BAD_INDEX;
				end else begin
					burst.op[0]   = fslp_pkg::OP_READ;
					burst.addr[0] = fslp_pkg::flash_address(base_address, idx_off);
				end
			end
			default: begin
			end
		endcase

		// Apply an append attempt
		if (do_att) begin
			nxt.rd_off   = cur.wr_off;
			nxt.wr_off   = att_wr;
			nxt.phase    = fslp_pkg::PH_VERIFY;
			burst.status = fslp_pkg::ST_WAIT;
			if (att_erase) begin
				nxt.count     = fslp_pkg::count_inc('0);
				burst.n       = 2'd3;
				burst.op[0]   = fslp_pkg::OP_ERASE;
				burst.addr[0] = fslp_pkg::flash_address(base_address, '0);
				burst.op[1]   = fslp_pkg::OP_WRITE;
				burst.addr[1] = fslp_pkg::flash_address(base_address, cur.wr_off);
				burst.op[2]   = fslp_pkg::OP_READ;
				burst.addr[2] = fslp_pkg::flash_address(base_address, cur.wr_off);
			end else begin
				nxt.count     = fslp_pkg::count_inc(cur.count);
				burst.n       = 2'd2;
				burst.op[0]   = fslp_pkg::OP_WRITE;
				burst.addr[0] = fslp_pkg::flash_address(base_address, cur.wr_off);
				burst.op[1]   = fslp_pkg::OP_READ;
				burst.addr[1] = fslp_pkg::flash_address(base_address, cur.wr_off);
			end
		end

		// Status shared by every request of the burst
		burst.count = nxt.count;
		burst.full  = (nxt.count == fslp_pkg::COUNT_BITS'(slots_in_sector));
		burst.empty = (nxt.count == '0);
	end

endmodule

[dv/flash_sector_item_log_pointers_core_check.sv]
// ----------------------------------------------------------------------------
// flash_sector_item_log_pointers_core_check - request checker of the item log
// Snoops the command and register ports, keeps its own copy of the log
// pointers and settings, works out the flash requests each accepted command
// should cause and compares every request shown on the result port with them.
// ----------------------------------------------------------------------------
module flash_sector_item_log_pointers_core_check (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [fslp_pkg::CMD_BITS-1:0]      cmd,
	input  logic                               check_flag,
	input  logic [fslp_pkg::INDEX_BITS-1:0]    item_index,
	input  logic                               cfg_we,
	input  logic [fslp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [fslp_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                               done,
	input  logic [1:0]                         flash_op,
	input  logic [fslp_pkg::ADDR_BITS-1:0]     flash_addr,
	input  logic [1:0]                         status,
	input  logic [fslp_pkg::COUNT_BITS-1:0]    item_count,
	input  logic                               is_full,
	input  logic                               is_empty,
	input  logic                               last,
	output int                                 fail_count,
	output int                                 pending
);
	import fslp_pkg::*;

	localparam int PRINT_CAP = 50;

	typedef struct packed {
		op_t                   op;
		logic [ADDR_BITS-1:0]  addr;
		status_t               status;
		logic [COUNT_BITS-1:0] count;
		logic                  full;
		logic                  empty;
		logic                  last;
	} flash_req_t;

	// Log pointers and settings as this checker sees them
	logic [OFF_BITS-1:0]   wr_off;
	logic [OFF_BITS-1:0]   rd_off;
	logic [OFF_BITS-1:0]   scan_off;
	logic [OFF_BITS-1:0]   start_off;
	logic [COUNT_BITS-1:0] n_items;
	phase_t                log_phase;
	logic [ADDR_BITS-1:0]  base_q;
	logic [SIZE_BITS-1:0]  size_q;
	logic [SLOT_BITS-1:0]  slots_q;

	flash_req_t burst[$];
	flash_req_t expected_reqs[$];
	int         errors = 0;
	int         outstanding = 0;

	assign fail_count = errors;
	assign pending    = outstanding;

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_CAP)
			$display("request mismatch: %s", msg);
		errors++;
	endtask

	// Bytes a slot really takes: zero counts as one, oversize is capped
	function automatic int unsigned slot_bytes();
		if (size_q == '0)
			return 1;
		if (size_q > MAX_ITEM_BYTES)
			return MAX_ITEM_BYTES;
		return int'(size_q);
	endfunction

	// A forward scan may read a slot while a further whole slot fits after it
	function automatic bit slot_readable(input int unsigned off);
		int unsigned two;
		two = 2 * slot_bytes();
		return (two <= SECTOR_BYTES) && (off <= SECTOR_BYTES - two);
	endfunction

	function automatic void add_req(input op_t op, input logic [OFF_BITS-1:0] off,
			input status_t st);
		flash_req_t r;
		r        = '0;
		r.op     = op;
		r.addr   = (op == OP_NONE) ? '0 : base_q + ADDR_BITS'(off);
		r.status = st;
		burst.push_back(r);
	endfunction

	function automatic void bump_count();
		if (n_items != '1)
			n_items = n_items + 1'b1;
	endfunction

	// One append attempt: erase at write offset zero, write, then read back
	function automatic void try_append();
		int unsigned it, nxt;
		it = slot_bytes();
		if (wr_off == '0) begin
			rd_off  = '0;
			n_items = '0;
			add_req(OP_ERASE, '0, ST_WAIT);
		end
		add_req(OP_WRITE, wr_off, ST_WAIT);
		bump_count();
		rd_off = wr_off;
		nxt = wr_off + it;
		if (nxt + it > SECTOR_BYTES)
			nxt = 0;
		wr_off = OFF_BITS'(nxt);
		add_req(OP_READ, rd_off, ST_WAIT);
		log_phase = PH_VERIFY;
	endfunction

	// Work out the requests of one accepted command and queue them
	function automatic void plan_flash_requests(input logic [CMD_BITS-1:0] c, input logic flag,
			input logic [INDEX_BITS-1:0] idx);
		int unsigned it, nxt;
		it = slot_bytes();
		burst.delete();
		case (c)
			CMD_SCAN: begin
				scan_off  = OFF_BITS'((32'(slots_q) - 1) * it);
				log_phase = PH_SCAN_LAST;
				add_req(OP_READ, scan_off, ST_WAIT);
			end
			CMD_CHECK: begin
				if (log_phase == PH_SCAN_LAST) begin
					wr_off = '0;
					if (flag) begin
						// last slot dirty: the sector is full
						rd_off    = scan_off;
						n_items   = slots_q;
						log_phase = PH_IDLE;
						add_req(OP_NONE, '0, ST_OK);
					end else begin
						rd_off   = '0;
						n_items  = '0;
						scan_off = '0;
						if (slot_readable(0)) begin
							log_phase = PH_SCAN_FWD;
							add_req(OP_READ, '0, ST_WAIT);
						end else begin
							log_phase = PH_IDLE;
							add_req(OP_NONE, '0, ST_OK);
						end
					end
				end else if (log_phase == PH_SCAN_FWD) begin
					if (flag) begin
						nxt = scan_off + it;
						bump_count();
						rd_off = scan_off;
						if (nxt < SECTOR_BYTES && slot_readable(nxt)) begin
							scan_off = OFF_BITS'(nxt);
							add_req(OP_READ, scan_off, ST_WAIT);
						end else begin
							log_phase = PH_IDLE;
							add_req(OP_NONE, '0, ST_OK);
						end
					end else begin
						// first clean slot takes the next write
						wr_off    = scan_off;
						log_phase = PH_IDLE;
						add_req(OP_NONE, '0, ST_OK);
					end
				end
			end
			CMD_APPEND: begin
				start_off = wr_off;
				try_append();
			end
			CMD_VERIFY: begin
				if (log_phase == PH_VERIFY) begin
					if (flag) begin
						log_phase = PH_IDLE;
						add_req(OP_NONE, '0, ST_OK);
					end else if (start_off == wr_off) begin
						// back where the append began: give up
						log_phase = PH_IDLE;
						add_req(OP_NONE, '0, ST_FAIL);
					end else begin
						try_append();
					end
				end
			end
			CMD_READ: begin
				if (32'(idx) >= 32'(n_items))
					add_req(OP_NONE, '0, ST_BAD_INDEX);
				else
					add_req(OP_READ, OFF_BITS'(32'(idx) * it), ST_OK);
			end
			default: ;
		endcase
		// count and flags show the state after the whole command
		foreach (burst[k]) begin
			burst[k].count = n_items;
			burst[k].full  = (n_items == slots_q);
			burst[k].empty = (n_items == '0);
			burst[k].last  = (k == burst.size() - 1);
			expected_reqs.push_back(burst[k]);
		end
	endfunction

	// Compare shown requests, then take register writes and new commands
	always @(posedge clk or negedge arst_n) begin : watch
		flash_req_t want;
		if (!arst_n) begin
			wr_off    = '0;
			rd_off    = '0;
			scan_off  = '0;
			start_off = '0;
			n_items   = '0;
			log_phase = PH_IDLE;
			base_q    = BASE_RESET;
			size_q    = SIZE_RESET;
			slots_q   = SLOTS_RESET;
			expected_reqs.delete();
			outstanding = 0;
		end else begin
			if (done) begin
				if (expected_reqs.size() == 0) begin
					report_mismatch($sformatf("unexpected request op %0d addr %0h",
						flash_op, flash_addr));
				end else begin
					want = expected_reqs.pop_front();
					if (flash_op !== want.op)
						report_mismatch($sformatf("flash_op %0d, want %0d",
							flash_op, want.op));
					if (flash_addr !== want.addr)
						report_mismatch($sformatf("flash_addr %0h, want %0h",
							flash_addr, want.addr));
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							status, want.status));
					if (item_count !== want.count)
						report_mismatch($sformatf("item_count %0d, want %0d",
							item_count, want.count));
					if (is_full !== want.full)
						report_mismatch($sformatf("is_full %0b, want %0b",
							is_full, want.full));
					if (is_empty !== want.empty)
						report_mismatch($sformatf("is_empty %0b, want %0b",
							is_empty, want.empty));
					if (last !== want.last)
						report_mismatch($sformatf("last %0b, want %0b", last, want.last));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_BASE:      base_q = cfg_data[ADDR_BITS-1:0];
					CFG_ITEM_SIZE: size_q = cfg_data[SIZE_BITS-1:0];
					CFG_SLOTS:     slots_q = cfg_data[SLOT_BITS-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				plan_flash_requests(cmd, check_flag, item_index);
			outstanding = expected_reqs.size();
		end
	end

endmodule

[dv/flash_sector_item_log_pointers_core_test.sv]
// ----------------------------------------------------------------------------
// flash_sector_item_log_pointers_core_test - testbench of the item log core
// Drives directed and random scan, slot check, append, verify and indexed
// read requests under several register settings with random idle gaps; a
// checker beside the block predicts and compares every flash request.
// ----------------------------------------------------------------------------
module flash_sector_item_log_pointers_core_test;
	import fslp_pkg::*;

	localparam int ITEM_GOAL     = 180;
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_LIMIT   = 200;
	localparam int CHAIN_CAP     = 40;
	localparam int RUN_LIMIT     = 400000;
	localparam logic [CMD_BITS-1:0] CMD_UNUSED_LO = 3'd5;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [CMD_BITS-1:0]      cmd = '0;
	logic                     check_flag = 1'b0;
	logic [INDEX_BITS-1:0]    item_index = '0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     busy;
	logic                     done;
	logic [1:0]               flash_op;
	logic [ADDR_BITS-1:0]     flash_addr;
	logic [1:0]               status;
	logic [COUNT_BITS-1:0]    item_count;
	logic                     is_full;
	logic                     is_empty;
	logic                     last;
	int                       fail_count;
	int                       pending;

	logic [COUNT_BITS-1:0]    seen_count = '0;
	logic [SIZE_BITS-1:0]     size_now = SIZE_RESET;
	bit                       no_idle = 1'b0;
	int                       items_sent = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	flash_sector_item_log_pointers_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.check_flag (check_flag),
		.item_index (item_index),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.flash_op   (flash_op),
		.flash_addr (flash_addr),
		.status     (status),
		.item_count (item_count),
		.is_full    (is_full),
		.is_empty   (is_empty),
		.last       (last)
	);

	flash_sector_item_log_pointers_core_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.check_flag (check_flag),
		.item_index (item_index),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.flash_op   (flash_op),
		.flash_addr (flash_addr),
		.status     (status),
		.item_count (item_count),
		.is_full    (is_full),
		.is_empty   (is_empty),
		.last       (last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Track the shown count so read indexes land near the boundary
	always @(posedge clk) begin
		if (done)
			seen_count <= item_count;
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Offer one request and hold it until taken; keep start high when no gap follows
	task automatic send_request(input logic [CMD_BITS-1:0] c, input logic flag,
			input logic [INDEX_BITS-1:0] idx, input bit counts);
		int gap;
		start      <= 1'b1;
		cmd        <= c;
		check_flag <= flag;
		item_index <= idx;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (counts)
			items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop start, wait for every predicted request (up to DRAIN_LIMIT), then idle
	task automatic settle();
		int waited;
		start <= 1'b0;
		waited = 0;
		do begin
			@(negedge clk);
			waited++;
		end while (pending != 0 && waited < DRAIN_LIMIT);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_registers(input logic [ADDR_BITS-1:0] base,
			input logic [SIZE_BITS-1:0] size, input logic [SLOT_BITS-1:0] slots);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BASE;
		cfg_data  <= CFG_DATA_BITS'(base);
		@(posedge clk);
		cfg_index <= CFG_ITEM_SIZE;
		cfg_data  <= CFG_DATA_BITS'(size);
		@(posedge clk);
		cfg_index <= CFG_SLOTS;
		cfg_data  <= CFG_DATA_BITS'(slots);
		@(posedge clk);
		cfg_we   <= 1'b0;
		size_now = size;
	endtask

	function automatic logic [INDEX_BITS-1:0] pick_index();
		int r;
		int top;
		r = $urandom_range(0, 9);
		top = (seen_count > 4095) ? 4095 : int'(seen_count);
		if (r < 5)
			return INDEX_BITS'($urandom_range(0, top));
		if (r < 7)
			return INDEX_BITS'((top == 0) ? 0 : top - $urandom_range(0, 1));
		return INDEX_BITS'($urandom);
	endfunction

	// Append, then verify results or not: mostly a match, some retries, a few long runs of failed verifies
	task automatic run_append();
		int r, eff, chain;
		send_request(CMD_APPEND, 1'($urandom), INDEX_BITS'($urandom), 1'b1);
		r = $urandom_range(0, 19);
		if (r < 2)
			return;
		if (r < 12) begin
			send_request(CMD_VERIFY, 1'b1, INDEX_BITS'($urandom), 1'b1);
		end else if (r < 18) begin
			repeat ($urandom_range(1, 4))
				send_request(CMD_VERIFY, 1'b0, INDEX_BITS'($urandom), 1'b1);
			send_request(CMD_VERIFY, 1'b1, INDEX_BITS'($urandom), 1'b1);
		end else begin
			eff = (size_now == '0) ? 1 :
				(size_now > MAX_ITEM_BYTES) ? MAX_ITEM_BYTES : int'(size_now);
			chain = SECTOR_BYTES / eff;
			if (chain > CHAIN_CAP)
				chain = CHAIN_CAP;
			repeat (chain + 1)
				send_request(CMD_VERIFY, 1'b0, INDEX_BITS'($urandom), 1'b1);
		end
	endtask

	// Scan: last slot first, then a run of dirty slots mostly closed by a clean one
	task automatic run_scan();
		int dirty;
		send_request(CMD_SCAN, 1'($urandom), INDEX_BITS'($urandom), 1'b1);
		if ($urandom_range(0, 4) == 0) begin
			send_request(CMD_CHECK, 1'b1, INDEX_BITS'($urandom), 1'b1);
			return;
		end
		send_request(CMD_CHECK, 1'b0, INDEX_BITS'($urandom), 1'b1);
		dirty = ($urandom_range(0, 4) == 0) ? $urandom_range(0, CHAIN_CAP) :
			$urandom_range(0, 6);
		repeat (dirty)
			send_request(CMD_CHECK, 1'b1, INDEX_BITS'($urandom), 1'b1);
		if ($urandom_range(0, 9) != 0)
			send_request(CMD_CHECK, 1'b0, INDEX_BITS'($urandom), 1'b1);
	endtask

	task automatic run_reads();
		repeat ($urandom_range(1, 3))
			send_request(CMD_READ, 1'($urandom), pick_index(), 1'b1);
	endtask

	// Noise: any code with any content, stray results included
	task automatic run_noise();
		send_request(CMD_BITS'($urandom), 1'($urandom), INDEX_BITS'($urandom), 1'b0);
	endtask

	task automatic pick_setting(input int n, output logic [ADDR_BITS-1:0] base,
			output logic [SIZE_BITS-1:0] size, output logic [SLOT_BITS-1:0] slots);
		base = ADDR_BITS'($urandom);
		case (n)
			0: begin
				base  = '1;
				size  = SIZE_BITS'(MAX_ITEM_BYTES);
				slots = SLOT_BITS'(SECTOR_BYTES / MAX_ITEM_BYTES);
			end
			1: begin
				base  = '0;
				size  = SIZE_BITS'(1);
				slots = SLOT_BITS'(SECTOR_BYTES);
			end
			2: begin
				size  = '0;
				slots = '0;
			end
			3: begin
				size  = '1;
				slots = '1;
			end
			4: begin
				size  = SIZE_BITS'(100);
				slots = SLOT_BITS'(SECTOR_BYTES / 100);
			end
			default: begin
				size = SIZE_BITS'($urandom_range(1, MAX_ITEM_BYTES));
				if ($urandom_range(0, 3) != 0)
					slots = SLOT_BITS'(SECTOR_BYTES / int'(size));
				else
					slots = SLOT_BITS'($urandom_range(1, 8191));
			end
		endcase
	endtask

	initial begin
		#(RUN_LIMIT);
		$display("flash_sector_item_log_pointers_core_test failed");
		$finish;
	end

	initial begin : stimulus
		logic [ADDR_BITS-1:0] base;
		logic [SIZE_BITS-1:0] size;
		logic [SLOT_BITS-1:0] slots;
		int                   phase_no;
		int                   r;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: empty reads, erase on first append, retry, stray results
		send_request(CMD_READ, 1'b0, 12'd0, 1'b1);
		send_request(CMD_APPEND, 1'b0, 12'd0, 1'b1);
		send_request(CMD_VERIFY, 1'b1, 12'd0, 1'b1);
		send_request(CMD_READ, 1'b0, 12'd0, 1'b1);
		send_request(CMD_READ, 1'b1, 12'd1, 1'b1);
		send_request(CMD_READ, 1'b1, 12'd4095, 1'b1);
		send_request(CMD_APPEND, 1'b1, 12'd4095, 1'b1);
		send_request(CMD_VERIFY, 1'b0, 12'd0, 1'b1);
		send_request(CMD_VERIFY, 1'b1, 12'd0, 1'b1);
		send_request(CMD_CHECK, 1'b1, 12'd0, 1'b1);
		send_request(CMD_VERIFY, 1'b1, 12'd0, 1'b1);
		for (int k = 0; k < 3; k++)
			send_request(CMD_UNUSED_LO + CMD_BITS'(k), 1'b1, 12'd4095, 1'b1);
		// Full sector, then an append abandoned by a scan that finds a clean slot
		send_request(CMD_SCAN, 1'b0, 12'd0, 1'b1);
		send_request(CMD_CHECK, 1'b1, 12'd0, 1'b1);
		send_request(CMD_READ, 1'b0, 12'd255, 1'b1);
		send_request(CMD_APPEND, 1'b0, 12'd0, 1'b1);
		send_request(CMD_SCAN, 1'b0, 12'd0, 1'b1);
		send_request(CMD_CHECK, 1'b0, 12'd0, 1'b1);
		send_request(CMD_CHECK, 1'b1, 12'd0, 1'b1);
		send_request(CMD_CHECK, 1'b1, 12'd0, 1'b1);
		send_request(CMD_CHECK, 1'b0, 12'd0, 1'b1);
		send_request(CMD_APPEND, 1'b0, 12'd0, 1'b1);
		send_request(CMD_VERIFY, 1'b1, 12'd0, 1'b1);
		settle();

		// Random phases, each under a new setting, extremes first
		items_sent = 0;
		phase_no = 0;
		while (items_sent < ITEM_GOAL) begin
			pick_setting(phase_no, base, size, slots);
			write_registers(base, size, slots);
			no_idle = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(4, 10)) begin
				r = $urandom_range(0, 99);
				if (r < 40)
					run_append();
				else if (r < 65)
					run_scan();
				else if (r < 90)
					run_reads();
				else
					run_noise();
			end
			settle();
			phase_no++;
		end
		no_idle = 1'b0;
		settle();

		if (fail_count == 0 && pending == 0)
			$display("flash_sector_item_log_pointers_core_test passed");
		else
			$display("flash_sector_item_log_pointers_core_test failed");
		$finish;
	end

endmodule
